@@ hdl/mea_pkg.sv @@
// mesh edge adjacency: shared command and status codes, fixed field widths
// no dependencies
`default_nettype none
package mea_pkg;

  // fixed payload widths
  localparam int CMD_W    = 2;
  localparam int VID_W    = 16;
  localparam int QEL_W    = 8;
  localparam int QED_W    = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

endpackage
`default_nettype wire

@@ hdl/mea_if.sv @@
// mesh edge adjacency: valid/ready channel interfaces for commands and results
// depends on mea_pkg
`default_nettype none
interface mea_in_if
  import mea_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [VID_W-1:0]   vertex_id;
  logic               closes_element;
  logic [QEL_W-1:0]   query_element;
  logic [QED_W-1:0]   query_edge;

  modport source (output valid, cmd, vertex_id, closes_element, query_element, query_edge,
                  input ready);
  modport sink (input valid, cmd, vertex_id, closes_element, query_element, query_edge,
                output ready);
endinterface

interface mea_out_if
  import mea_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                has_neighbour;
  logic [QEL_W-1:0]    neighbour_element;
  logic [QED_W-1:0]    neighbour_edge;

  modport source (output valid, status, has_neighbour, neighbour_element, neighbour_edge,
                  input ready);
  modport sink (input valid, status, has_neighbour, neighbour_element, neighbour_edge,
                output ready);
endinterface
`default_nettype wire

@@ hdl/mea_ram.sv @@
// mesh edge adjacency: generic single write, single read ram, registered read
// no dependencies
`default_nettype none
module mea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/mea_edge_match.sv @@
// mesh edge adjacency: compares one stored edge against every edge of the
// element being closed, one lane per edge; no package dependency
`default_nettype none
module mea_edge_match #(
  parameter int MAX_EDGES = 8,
  parameter int VB = 16,
  localparam int SW = $clog2(MAX_EDGES),
  localparam int CW = $clog2(MAX_EDGES + 1)
) (
  input  wire logic [VB-1:0]        lanes [MAX_EDGES],
  input  wire logic [CW-1:0]        nk,
  input  wire logic [VB-1:0]        a,
  input  wire logic [VB-1:0]        b,
  output logic      [MAX_EDGES-1:0] hit,
  output logic                      any,
  output logic      [SW-1:0]        last
);

  // one lane per edge of the new element: (c,d) against (a,b) reversed
  for (genvar t = 0; t < MAX_EDGES; t++) begin : g_lane
    localparam int NXT = (t + 1) % MAX_EDGES;
    logic [VB-1:0] d;
    assign d = (CW'(t + 1) < nk) ? lanes[NXT] : lanes[0];
    assign hit[t] = (CW'(t) < nk) && (a == d) && (b == lanes[t]);
  end

  // highest matching lane wins
  always_comb begin
    last = '0;
    for (int t = 0; t < MAX_EDGES; t++) begin
      if (hit[t]) begin
        last = SW'(t);
      end
    end
  end

  assign any = |hit;

endmodule
`default_nettype wire

@@ hdl/mesh_edge_adjacency_core.sv @@
// mesh edge adjacency top level: command decode, close sequencer, rams
// depends on mea_pkg, mea_if, mea_ram, mea_edge_match
//
//  channel  dir  transfer                              payload
//  in_ch    in   one command (load, query, clear)      cmd vertex_id closes_element
//                                                      query_element query_edge
//  out_ch   out  one result per command                status has_neighbour
//                                                      neighbour_element neighbour_edge
//
// load, clear: result registered the cycle after the transfer; query: registered
// in S_QRES after the neighbour ram read; a closing load then runs the close
// sequencer: per earlier element a count read, size latch, ni vertex reads and the
// wrap edge, then a last count check and nk write-backs into the neighbour ram
// in_ch.ready is low while a query or close runs and while a result waits untaken
// synchronous reset clears counts and control; rams need no clearing
`default_nettype none
module mesh_edge_adjacency_core
  import mea_pkg::*;
#(
  parameter int MAX_ELEMENTS = 256,
  parameter int MAX_EDGES = 8,
  parameter int VERTEX_BITS = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  mea_in_if.sink     in_ch,
  mea_out_if.source  out_ch
);

  localparam int SLOTS = MAX_ELEMENTS * MAX_EDGES;
  localparam int AW    = $clog2(SLOTS);
  localparam int EIW   = $clog2(MAX_ELEMENTS);
  localparam int EW    = $clog2(MAX_ELEMENTS + 1);
  localparam int SW    = $clog2(MAX_EDGES);
  localparam int CW    = $clog2(MAX_EDGES + 1);
  localparam int NW    = 1 + EIW + SW;
  localparam int QCW   = (EW > QEL_W) ? EW : QEL_W;
  localparam int QW    = (CW > QED_W) ? CW : QED_W;

  typedef enum logic [2:0] {
    S_IDLE, S_QRES, S_CL_CNT, S_CL_NI, S_CL_RUN, S_CL_WB
  } state_t;

  function automatic logic [AW-1:0] slot_addr(input logic [EIW-1:0] e,
                                               input logic [SW-1:0] s);
    return AW'(e) * AW'(MAX_EDGES) + AW'(s);
  endfunction

  state_t state;
  logic [EW-1:0]          element_count;
  logic [CW-1:0]          open_cnt;
  logic [VERTEX_BITS-1:0] lanes [MAX_EDGES];
  logic [EIW-1:0]         k;
  logic [CW-1:0]          nk;
  logic [EIW-1:0]         i;
  logic [CW-1:0]          ni;
  logic [CW-1:0]          rd_slot;
  logic                   pend;
  logic [SW-1:0]          pend_slot;
  logic [VERTEX_BITS-1:0] first_v;
  logic [VERTEX_BITS-1:0] prev_v;
  logic                   kn_valid [MAX_EDGES];
  logic [EIW-1:0]         kn_elem [MAX_EDGES];
  logic [SW-1:0]          kn_edge [MAX_EDGES];
  logic [CW-1:0]          wb;
  logic                   q_inr;
  logic [QED_W-1:0]       q_edge;
  logic                   ov;
  logic [STATUS_W-1:0]    o_status;
  logic                   o_has;
  logic [QEL_W-1:0]       o_nel;
  logic [QED_W-1:0]       o_ned;

  // ram ports
  logic                   vtx_we;
  logic [AW-1:0]          vtx_waddr, vtx_raddr;
  logic [VERTEX_BITS-1:0] vtx_wdata, vtx_rdata;
  logic                   ec_we;
  logic [EIW-1:0]         ec_waddr, ec_raddr;
  logic [CW-1:0]          ec_wdata, ec_rdata;
  logic                   nb_we;
  logic [AW-1:0]          nb_waddr, nb_raddr;
  logic [NW-1:0]          nb_wdata, nb_rdata;

  // edge under comparison
  logic                   proc;
  logic [VERTEX_BITS-1:0] ea, eb;
  logic [SW-1:0]          es;
  logic [MAX_EDGES-1:0]   hit;
  logic                   any;
  logic [SW-1:0]          last;

  logic                   in_fire;
  logic                   load_full, load_long, load_store;
  logic [CW-1:0]          nk_new;
  logic [VERTEX_BITS-1:0] vid;
  logic                   q_bad;

  assign in_ch.ready = (state == S_IDLE) && (!ov || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign load_full   = (element_count == EW'(MAX_ELEMENTS));
  assign load_long   = (open_cnt == CW'(MAX_EDGES));
  assign load_store  = !load_full && !load_long;
  assign nk_new      = load_store ? open_cnt + CW'(1) : open_cnt;
  assign vid         = VERTEX_BITS'(in_ch.vertex_id);

  assign out_ch.valid             = ov;
  assign out_ch.status            = o_status;
  assign out_ch.has_neighbour     = o_has;
  assign out_ch.neighbour_element = o_nel;
  assign out_ch.neighbour_edge    = o_ned;

  // edge selection during the close sweep
  always_comb begin
    proc = 1'b0;
    ea   = prev_v;
    eb   = first_v;
    es   = SW'(ni - CW'(1));
    if (state == S_CL_RUN) begin
      if (pend) begin
        proc = (pend_slot != '0);
        eb   = vtx_rdata;
        es   = pend_slot - SW'(1);
      end else begin
        proc = 1'b1;
      end
    end
  end

  mea_edge_match #(.MAX_EDGES(MAX_EDGES), .VB(VERTEX_BITS)) u_match (
    .lanes(lanes), .nk(nk), .a(ea), .b(eb), .hit(hit), .any(any), .last(last)
  );

  // ram address and write control
  always_comb begin
    vtx_we    = in_fire && (cmd_t'(in_ch.cmd) == CMD_LOAD) && load_store;
    vtx_waddr = slot_addr(EIW'(element_count), SW'(open_cnt));
    vtx_wdata = vid;
    vtx_raddr = slot_addr(i, SW'(rd_slot));

    ec_we    = in_fire && (cmd_t'(in_ch.cmd) == CMD_LOAD) && !load_full
               && in_ch.closes_element;
    ec_waddr = EIW'(element_count);
    ec_wdata = nk_new;
    ec_raddr = (state == S_CL_CNT) ? i : EIW'(in_ch.query_element);

    nb_raddr = slot_addr(EIW'(in_ch.query_element), SW'(in_ch.query_edge));
    nb_we    = 1'b0;
    nb_waddr = slot_addr(i, es);
    nb_wdata = {1'b1, k, last};
    if (state == S_CL_RUN) begin
      nb_we = proc && any;
    end else if (state == S_CL_WB) begin
      nb_we    = 1'b1;
      nb_waddr = slot_addr(k, SW'(wb));
      nb_wdata = {kn_valid[SW'(wb)], kn_elem[SW'(wb)], kn_edge[SW'(wb)]};
    end
  end

  mea_ram #(.WIDTH(VERTEX_BITS), .DEPTH(SLOTS)) u_vtx_ram (
    .clk(clk), .we(vtx_we), .waddr(vtx_waddr), .wdata(vtx_wdata),
    .raddr(vtx_raddr), .rdata(vtx_rdata)
  );

  mea_ram #(.WIDTH(CW), .DEPTH(MAX_ELEMENTS)) u_ec_ram (
    .clk(clk), .we(ec_we), .waddr(ec_waddr), .wdata(ec_wdata),
    .raddr(ec_raddr), .rdata(ec_rdata)
  );

  mea_ram #(.WIDTH(NW), .DEPTH(SLOTS)) u_nb_ram (
    .clk(clk), .we(nb_we), .waddr(nb_waddr), .wdata(nb_wdata),
    .raddr(nb_raddr), .rdata(nb_rdata)
  );

  assign q_bad = !q_inr || (QW'(q_edge) >= QW'(ec_rdata));

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ov            <= 1'b0;
      element_count <= '0;
      open_cnt      <= '0;
      pend          <= 1'b0;
    end else begin
      if (ov && out_ch.ready) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            o_status <= ST_OK;
            o_has    <= 1'b0;
            o_nel    <= '0;
            o_ned    <= '0;
            case (cmd_t'(in_ch.cmd))
              CMD_LOAD: begin
                ov <= 1'b1;
                if (load_full || load_long) begin
                  o_status <= ST_OVERFLOW;
                end
                if (!load_full) begin
                  if (load_store) begin
                    lanes[SW'(open_cnt)] <= vid;
                    open_cnt             <= open_cnt + CW'(1);
                  end
                  if (in_ch.closes_element) begin
                    k       <= EIW'(element_count);
                    nk      <= nk_new;
                    i       <= '0;
                    rd_slot <= '0;
                    for (int t = 0; t < MAX_EDGES; t++) begin
                      kn_valid[t] <= 1'b0;
                    end
                    state <= S_CL_CNT;
                  end
                end
              end
              CMD_QUERY: begin
                q_inr  <= QCW'(in_ch.query_element) < QCW'(element_count);
                q_edge <= in_ch.query_edge;
                state  <= S_QRES;
              end
              CMD_CLEAR: begin
                ov            <= 1'b1;
                element_count <= '0;
                open_cnt      <= '0;
              end
              default: begin
                ov <= 1'b1;
              end
            endcase
          end
        end
        S_QRES: begin
          ov    <= 1'b1;
          state <= S_IDLE;
          if (q_bad) begin
            o_status <= ST_RANGE;
          end else if (nb_rdata[NW-1]) begin
            o_has <= 1'b1;
            o_nel <= QEL_W'(nb_rdata[SW +: EIW]);
            o_ned <= QED_W'(nb_rdata[SW-1:0]);
          end
        end
        S_CL_CNT: begin
          if (i == k) begin
            wb    <= '0;
            state <= S_CL_WB;
          end else begin
            state <= S_CL_NI;
          end
        end
        S_CL_NI: begin
          ni        <= ec_rdata;
          rd_slot   <= CW'(1);
          pend      <= 1'b1;
          pend_slot <= '0;
          state     <= S_CL_RUN;
        end
        S_CL_RUN: begin
          if (proc) begin
            for (int t = 0; t < MAX_EDGES; t++) begin
              if (hit[t]) begin
                kn_valid[t] <= 1'b1;
                kn_elem[t]  <= i;
                kn_edge[t]  <= es;
              end
            end
          end
          if (pend) begin
            if (pend_slot == '0) begin
              first_v <= vtx_rdata;
            end
            prev_v <= vtx_rdata;
            if (rd_slot < ni) begin
              pend      <= 1'b1;
              pend_slot <= SW'(rd_slot);
              rd_slot   <= rd_slot + CW'(1);
            end else begin
              pend <= 1'b0;
            end
          end else begin
            i       <= i + EIW'(1);
            rd_slot <= '0;
            state   <= S_CL_CNT;
          end
        end
        S_CL_WB: begin
          if (wb == nk - CW'(1)) begin
            element_count <= element_count + EW'(1);
            open_cnt      <= '0;
            state         <= S_IDLE;
          end else begin
            wb <= wb + CW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/mea_checker.sv @@
// mesh edge adjacency: port-level checks on the result channel, bound to the top
// depends on mea_pkg and mesh_edge_adjacency_core
`default_nettype none
module mea_checker
  import mea_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [STATUS_W-1:0] status,
  input wire logic                has_neighbour,
  input wire logic [QEL_W-1:0]    neighbour_element,
  input wire logic [QED_W-1:0]    neighbour_edge
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // no unused status code is ever shown
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("illegal status");

  // a result without neighbour carries zero neighbour fields
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_neighbour |-> neighbour_element == '0 && neighbour_edge == '0)
    else $error("neighbour fields not zero");

  // only an ok query can report a neighbour
  a_has_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_neighbour |-> status == ST_OK)
    else $error("neighbour reported with error status");

endmodule

bind mesh_edge_adjacency_core mea_checker u_mea_checker (
  .clk(clk), .rst(rst),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status), .has_neighbour(out_ch.has_neighbour),
  .neighbour_element(out_ch.neighbour_element), .neighbour_edge(out_ch.neighbour_edge)
);
`default_nettype wire

@@ verif/mea_scoreboard.sv @@
`timescale 1ns / 1ps
// mesh edge adjacency checker: watches both channels, predicts each result, compares
// depends on mea_pkg and mea_if
module mea_scoreboard
  import mea_pkg::*;
#(
  parameter int MAX_ELEMENTS = 256,
  parameter int MAX_EDGES = 8
) (
  input  logic clk,
  input  logic rst,
  mea_in_if    in_mon,
  mea_out_if   out_mon,
  output int   errors,
  output int   pending
);

  typedef struct {
    status_t            status;
    logic               has_neighbour;
    logic [QEL_W-1:0]   neighbour_element;
    logic [QED_W-1:0]   neighbour_edge;
  } adj_result_t;

  adj_result_t        adj_results_q[$];

  // mirror of the mesh tables
  logic [VID_W-1:0]   poly_vertex [MAX_ELEMENTS][MAX_EDGES];
  int                 poly_edges [MAX_ELEMENTS];
  bit                 link_valid [MAX_ELEMENTS][MAX_EDGES];
  logic [QEL_W-1:0]   link_elem [MAX_ELEMENTS][MAX_EDGES];
  logic [QED_W-1:0]   link_edge [MAX_ELEMENTS][MAX_EDGES];
  int                 closed_elems;
  int                 open_verts;

  // link a newly closed element against every earlier one
  task automatic close_polygon();
    int k;
    int nk;
    int ni;
    k = closed_elems;
    nk = open_verts;
    poly_edges[k] = nk;
    for (int t = 0; t < nk; t++) link_valid[k][t] = 0;
    for (int i = 0; i < k; i++) begin
      ni = poly_edges[i];
      for (int s = 0; s < ni; s++) begin
        for (int t = 0; t < nk; t++) begin
          if (poly_vertex[i][s] == poly_vertex[k][(t + 1) % nk] &&
              poly_vertex[i][(s + 1) % ni] == poly_vertex[k][t]) begin
            link_valid[i][s] = 1;
            link_elem[i][s] = k[QEL_W-1:0];
            link_edge[i][s] = t[QED_W-1:0];
            link_valid[k][t] = 1;
            link_elem[k][t] = i[QEL_W-1:0];
            link_edge[k][t] = s[QED_W-1:0];
          end
        end
      end
    end
    closed_elems = k + 1;
    open_verts = 0;
  endtask

  // predicted result of one accepted command
  task automatic predict_adjacency(output adj_result_t r);
    r = '{ST_OK, 1'b0, '0, '0};
    case (in_mon.cmd)
      CMD_LOAD: begin
        if (closed_elems >= MAX_ELEMENTS) begin
          r.status = ST_OVERFLOW;
        end else begin
          if (open_verts >= MAX_EDGES) begin
            r.status = ST_OVERFLOW;
          end else begin
            poly_vertex[closed_elems][open_verts] = in_mon.vertex_id;
            open_verts++;
          end
          if (in_mon.closes_element) close_polygon();
        end
      end
      CMD_QUERY: begin
        if (int'(in_mon.query_element) >= closed_elems ||
            int'(in_mon.query_edge) >= poly_edges[in_mon.query_element]) begin
          r.status = ST_RANGE;
        end else if (link_valid[in_mon.query_element][in_mon.query_edge]) begin
          r.has_neighbour = 1'b1;
          r.neighbour_element = link_elem[in_mon.query_element][in_mon.query_edge];
          r.neighbour_edge = link_edge[in_mon.query_element][in_mon.query_edge];
        end
      end
      CMD_CLEAR: begin
        foreach (link_valid[i, j]) link_valid[i][j] = 0;
        closed_elems = 0;
        open_verts = 0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    adj_result_t exp_r;
    if (rst) begin
      foreach (link_valid[i, j]) link_valid[i][j] = 0;
      closed_elems = 0;
      open_verts = 0;
      errors = 0;
      adj_results_q.delete();
    end else begin
      // command transfer: predict
      if (in_mon.valid && in_mon.ready) begin
        predict_adjacency(exp_r);
        adj_results_q.push_back(exp_r);
      end
      // result transfer: compare with oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (adj_results_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result status=%0d", $time, out_mon.status);
        end else begin
          exp_r = adj_results_q.pop_front();
          if (out_mon.status !== exp_r.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                     out_mon.status);
          end
          if (out_mon.has_neighbour !== exp_r.has_neighbour) begin
            errors++;
            $display("%0t: has_neighbour expected %0d actual %0d", $time,
                     exp_r.has_neighbour, out_mon.has_neighbour);
          end
          if (out_mon.neighbour_element !== exp_r.neighbour_element) begin
            errors++;
            $display("%0t: neighbour_element expected %0d actual %0d", $time,
                     exp_r.neighbour_element, out_mon.neighbour_element);
          end
          if (out_mon.neighbour_edge !== exp_r.neighbour_edge) begin
            errors++;
            $display("%0t: neighbour_edge expected %0d actual %0d", $time,
                     exp_r.neighbour_edge, out_mon.neighbour_edge);
          end
        end
      end
    end
    pending = adj_results_q.size();
  end

endmodule

@@ verif/mesh_edge_adjacency_core_tb.sv @@
`timescale 1ns / 1ps
// mesh edge adjacency testbench top: clock, reset, command stimulus, result sink, verdict
// depends on mea_pkg, mea_if, mea_scoreboard and the core
module mesh_edge_adjacency_core_tb;
  import mea_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 20;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   sent;
  int   received;
  bit   long_hold;

  mea_in_if  in_ch ();
  mea_out_if out_ch ();

  mesh_edge_adjacency_core uut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  mea_scoreboard chk (
    .clk    (clk),
    .rst    (rst),
    .in_mon (in_ch),
    .out_mon(out_ch),
    .errors (errors),
    .pending(pending)
  );

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // one command transfer; valid stays high across back-to-back items
  task automatic send_cmd(logic [CMD_W-1:0] c, logic [VID_W-1:0] vid, logic cl,
                          logic [QEL_W-1:0] qel, logic [QED_W-1:0] qed);
    int gap;
    gap = ((sent / 25) % 4 == 3) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.vertex_id <= vid;
    in_ch.closes_element <= cl;
    in_ch.query_element <= qel;
    in_ch.query_edge <= qed;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  // result sink with random stalls
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    received = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = ((received / 25) % 4 == 1) ? 0 : $urandom_range(0, 12);
      if (n > 0 || long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
        while (long_hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      received++;
    end
  end

  // long receiver hold-off so the core backs up and stalls commands
  initial begin
    long_hold <= 1'b0;
    wait (sent >= 40);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (400) @(posedge clk);
    long_hold <= 1'b0;
  end

  // stimulus
  initial begin
    logic [VID_W-1:0] poly [10];
    logic [VID_W-1:0] last_poly [10];
    int last_n;
    int n;
    int r;
    int closed;
    int rnd_sent;
    sent = 0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= CMD_LOAD;
    in_ch.vertex_id <= '0;
    in_ch.closes_element <= 1'b0;
    in_ch.query_element <= '0;
    in_ch.query_edge <= '0;
    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: query on empty mesh, triangle, reversed neighbor
    send_cmd(CMD_QUERY, 16'hFFFF, 1'b1, 8'd0, 3'd0);
    send_cmd(CMD_LOAD, 16'd1, 1'b0, 8'hFF, 3'd7);
    send_cmd(CMD_LOAD, 16'd2, 1'b0, 8'd0, 3'd0);
    send_cmd(CMD_LOAD, 16'd3, 1'b1, 8'd0, 3'd0);
    send_cmd(CMD_LOAD, 16'd2, 1'b0, 8'd0, 3'd0);
    send_cmd(CMD_LOAD, 16'd1, 1'b0, 8'd0, 3'd0);
    send_cmd(CMD_QUERY, 16'd0, 1'b0, 8'd1, 3'd0);   // element still open
    send_cmd(CMD_LOAD, 16'd4, 1'b1, 8'd0, 3'd0);
    send_cmd(CMD_QUERY, 16'd0, 1'b0, 8'd0, 3'd0);
    send_cmd(CMD_QUERY, 16'd0, 1'b0, 8'd1, 3'd0);
    send_cmd(CMD_QUERY, 16'd0, 1'b0, 8'd0, 3'd3);   // edge past element size
    // one-vertex and two-vertex elements
    send_cmd(CMD_LOAD, 16'hFFFF, 1'b1, 8'd0, 3'd0);
    send_cmd(CMD_LOAD, 16'd0, 1'b0, 8'd0, 3'd0);
    send_cmd(CMD_LOAD, 16'hFFFF, 1'b1, 8'd0, 3'd0);
    send_cmd(CMD_QUERY, 16'd0, 1'b0, 8'd3, 3'd1);
    // overlong element: ninth vertex dropped, still closes
    for (int j = 0; j < 9; j++) send_cmd(CMD_LOAD, 16'(j + 10), j == 8, 8'd0, 3'd0);
    send_cmd(CMD_QUERY, 16'd0, 1'b0, 8'd4, 3'd7);
    send_cmd(CMD_UNUSED, 16'hFFFF, 1'b1, 8'hFF, 3'd7);
    send_cmd(CMD_QUERY, 16'd0, 1'b0, 8'hFF, 3'd7);
    send_cmd(CMD_CLEAR, 16'd0, 1'b0, 8'd0, 3'd0);
    send_cmd(CMD_QUERY, 16'd0, 1'b0, 8'd0, 3'd0);

    // fill the mesh with one-vertex elements, then hit the full mesh
    for (int j = 0; j < 256; j++) send_cmd(CMD_LOAD, 16'(j % 3), 1'b1, 8'd0, 3'd0);
    send_cmd(CMD_LOAD, 16'd5, 1'b1, 8'd0, 3'd0);
    send_cmd(CMD_QUERY, 16'd0, 1'b0, 8'd255, 3'd0);
    send_cmd(CMD_QUERY, 16'd0, 1'b0, 8'd255, 3'd1);
    send_cmd(CMD_CLEAR, 16'd0, 1'b0, 8'd0, 3'd0);

    // random polygons, many sharing reversed edges with the previous one
    closed = 0;
    last_n = 0;
    rnd_sent = 0;
    while (rnd_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 5) n = 1;
      else if (r < 10) n = 2;
      else if (r < 60) n = 3;
      else if (r < 85) n = 4;
      else if (r < 95) n = $urandom_range(5, 8);
      else n = $urandom_range(9, 10);
      if ($urandom_range(0, 99) < 40 && last_n > 0) begin
        n = last_n;
        for (int j = 0; j < n; j++) poly[j] = last_poly[n - 1 - j];
      end else begin
        for (int j = 0; j < n; j++)
          poly[j] = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 11))
                                                 : 16'($urandom_range(0, 65535));
      end
      for (int j = 0; j < n; j++) begin
        if ($urandom_range(0, 99) < 15) begin
          send_cmd(CMD_QUERY, 16'($urandom), 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, closed)), 3'($urandom_range(0, 7)));
          rnd_sent++;
        end
        send_cmd(CMD_LOAD, poly[j], j == n - 1, 8'($urandom), 3'($urandom));
        rnd_sent++;
      end
      closed++;
      last_n = (n > 8) ? 8 : n;
      for (int j = 0; j < last_n; j++) last_poly[j] = poly[j];
      // queries on closed elements, a few out of range
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 99) < 10)
          send_cmd(CMD_QUERY, 16'($urandom), 1'($urandom_range(0, 1)), 8'($urandom),
                   3'($urandom));
        else
          send_cmd(CMD_QUERY, 16'($urandom), 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, closed - 1)), 3'($urandom_range(0, 7)));
        rnd_sent++;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_cmd(CMD_UNUSED, 16'($urandom), 1'($urandom_range(0, 1)), 8'($urandom),
                 3'($urandom));
        rnd_sent++;
      end else if (r < 5 || closed >= 150) begin
        send_cmd(CMD_CLEAR, 16'($urandom), 1'($urandom_range(0, 1)), 8'($urandom),
                 3'($urandom));
        rnd_sent++;
        closed = 0;
        last_n = 0;
      end
    end
    in_ch.valid <= 1'b0;

    // drain and verdict
    do @(posedge clk); while (pending != 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("** mesh_edge_adjacency_core: PASSED **");
    end else begin
      $display("** mesh_edge_adjacency_core: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("** mesh_edge_adjacency_core: FAILED **");
    $finish;
  end

endmodule

@@ mesh_edge_adjacency_core.f @@
hdl/mea_pkg.sv
hdl/mea_if.sv
hdl/mea_ram.sv
hdl/mea_edge_match.sv
hdl/mesh_edge_adjacency_core.sv
hdl/mea_checker.sv
verif/mea_scoreboard.sv
verif/mesh_edge_adjacency_core_tb.sv
